FILE: hw/rtl/scrm_pkg.sv
// Shared types and constants for the sorted channel route map.
`default_nettype none
package scrm_pkg;

    localparam int NUM_IN    = 16;
    localparam int NUM_OUT   = 16;
    localparam int SRC_W     = 4;
    localparam int DST_W     = 4;
    localparam int SLOT_W    = 5;
    localparam int LIM_W     = 5;
    localparam int SLOT_IDX_W = 4;

    localparam logic [SLOT_W-1:0] EMPTY_SLOT = 5'h1F;
    localparam logic [LIM_W-1:0]  NUM_IN_LIM  = 5'd16;
    localparam logic [LIM_W-1:0]  NUM_OUT_LIM = 5'd16;

    localparam logic CFG_INPUTS  = 1'b0;
    localparam logic CFG_OUTPUTS = 1'b1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef t_slot [NUM_OUT-1:0] t_row;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status status;
        t_row    row;
    } t_edit;

endpackage
`default_nettype wire

FILE: hw/rtl/sorted_channel_route_map.sv
// Top level of the sorted channel route map with its row memory and sequencer.
// Add, remove, clear and out-of-range items give their result from the S_EXEC state.
// A read row item of a non-empty row passes S_EXEC, then S_EMIT gives one result per cycle.
// The row memory has one read-modify-write port, so busy stays high in S_EXEC for each
// add, remove or clear item, and also in S_EMIT while a read row gives its entries.
// Synchronous reset clears the row valid bits, so every row reads empty at once.
`default_nettype none
module sorted_channel_route_map (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_op,
    input  wire logic [scrm_pkg::SRC_W-1:0]        i_source_channel,
    input  wire logic [scrm_pkg::DST_W-1:0]        i_dest_channel,
    output logic                                   o_valid,
    output logic [1:0]                             o_status,
    output logic [scrm_pkg::DST_W-1:0]             o_routed_channel,
    output logic                                   o_row_empty,
    output logic                                   o_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [scrm_pkg::LIM_W-1:0]        i_cfg_data
);

    scrm_pkg::t_state r_state, n_state;
    scrm_pkg::t_op    r_op;
    logic [scrm_pkg::SRC_W-1:0] r_src;
    logic [scrm_pkg::DST_W-1:0] r_dst;
    logic r_bad;
    logic [scrm_pkg::LIM_W-1:0] r_inputs_in_use;
    logic [scrm_pkg::LIM_W-1:0] r_outputs_in_use;

    scrm_pkg::t_row mem [scrm_pkg::NUM_IN];
    scrm_pkg::t_row r_rd_data;
    logic           r_rd_vld;
    logic [scrm_pkg::NUM_IN-1:0] r_row_vld;

    scrm_pkg::t_row r_row, n_row;
    logic [scrm_pkg::SLOT_IDX_W-1:0] r_cnt, n_cnt;

    logic n_valid, n_row_empty, n_last;
    scrm_pkg::t_status n_status;
    logic [scrm_pkg::DST_W-1:0] n_routed;

    logic accept;
    logic cfg_wr;
    logic [scrm_pkg::LIM_W-1:0] in_lim, out_lim;
    logic src_bad, dst_bad;
    scrm_pkg::t_row cur_row;
    scrm_pkg::t_row emit_shift;
    scrm_pkg::t_edit edit;
    logic wr_en;
    logic clr_all;
    logic emit_last;

    assign busy        = r_state != scrm_pkg::S_IDLE;
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign in_lim  = (r_inputs_in_use > scrm_pkg::NUM_IN_LIM) ? scrm_pkg::NUM_IN_LIM
                                                               : r_inputs_in_use;
    assign out_lim = (r_outputs_in_use > scrm_pkg::NUM_OUT_LIM) ? scrm_pkg::NUM_OUT_LIM
                                                                 : r_outputs_in_use;
    assign src_bad = {1'b0, i_source_channel} >= in_lim;
    assign dst_bad = {1'b0, i_dest_channel} >= out_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs_in_use  <= scrm_pkg::NUM_IN_LIM;
            r_outputs_in_use <= scrm_pkg::NUM_OUT_LIM;
        end else if (cfg_wr) begin
            if (i_cfg_index == scrm_pkg::CFG_INPUTS) begin
                r_inputs_in_use <= i_cfg_data;
            end else begin
                r_outputs_in_use <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= scrm_pkg::t_op'(i_op);
            r_src <= i_source_channel;
            r_dst <= i_dest_channel;
            r_bad <= src_bad || (scrm_pkg::t_op'(i_op) != scrm_pkg::OP_READ && dst_bad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_src] <= edit.row;
        end
        r_rd_data <= mem[i_source_channel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (clr_all) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[r_src] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[i_source_channel];
    end

    always_comb begin
        for (int j = 0; j < scrm_pkg::NUM_OUT; j++) begin
            cur_row[j] = r_rd_vld ? r_rd_data[j] : scrm_pkg::EMPTY_SLOT;
        end
    end

    scrm_row_edit u_row_edit (
        .i_op   (r_op),
        .i_row  (cur_row),
        .i_dst  (r_dst),
        .o_edit (edit)
    );

    assign emit_shift = {scrm_pkg::EMPTY_SLOT, r_row[scrm_pkg::NUM_OUT-1:1]};
    assign emit_last  = (r_row[1] == scrm_pkg::EMPTY_SLOT) ||
                        (r_cnt == scrm_pkg::SLOT_IDX_W'(scrm_pkg::NUM_OUT - 1));

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_valid     = 1'b0;
        n_status    = scrm_pkg::ST_OK;
        n_routed    = '0;
        n_row_empty = 1'b0;
        n_last      = 1'b0;
        wr_en       = 1'b0;
        clr_all     = 1'b0;
        case (r_state)
            scrm_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = scrm_pkg::S_EXEC;
                end
            end
            scrm_pkg::S_EXEC: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_state = scrm_pkg::S_IDLE;
                if (r_op == scrm_pkg::OP_CLEAR) begin
                    clr_all = 1'b1;
                end else if (r_bad) begin
                    n_status = scrm_pkg::ST_RANGE;
                end else if (r_op == scrm_pkg::OP_READ) begin
                    if (cur_row[0] == scrm_pkg::EMPTY_SLOT) begin
                        n_row_empty = 1'b1;
                    end else begin
                        n_valid = 1'b0;
                        n_last  = 1'b0;
                        n_row   = cur_row;
                        n_cnt   = '0;
                        n_state = scrm_pkg::S_EMIT;
                    end
                end else begin
                    n_status = edit.status;
                    wr_en    = edit.status == scrm_pkg::ST_OK;
                end
            end
            scrm_pkg::S_EMIT: begin
                n_valid  = 1'b1;
                n_routed = r_row[0][scrm_pkg::DST_W-1:0];
                n_last   = emit_last;
                n_row    = emit_shift;
                n_cnt    = r_cnt + 1'b1;
                if (emit_last) begin
                    n_state = scrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scrm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scrm_pkg::S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row            <= n_row;
        r_cnt            <= n_cnt;
        o_status         <= n_status;
        o_routed_channel <= n_routed;
        o_row_empty      <= n_row_empty;
        o_last           <= n_last;
    end

`ifndef NO_ASSERTIONS
    a_no_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_valid)
        else $error("result strobe directly after an accepted item");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result strobe directly after a final result");

    a_empty_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_row_empty) |-> (o_last && o_status == scrm_pkg::ST_OK))
        else $error("empty row result is not a single ok result");

    a_mid_row_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == scrm_pkg::ST_OK && !o_row_empty))
        else $error("non-final result that is not a row entry");

    a_write_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == scrm_pkg::S_EXEC && !r_bad))
        else $error("row write outside an in-range add or remove");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/scrm_row_edit.sv
// Sorted insert and delete on one row of the route table.
`default_nettype none
module scrm_row_edit (
    input  var scrm_pkg::t_op                     i_op,
    input  var scrm_pkg::t_row                    i_row,
    input  wire logic [scrm_pkg::DST_W-1:0]       i_dst,
    output scrm_pkg::t_edit                       o_edit
);

    logic [scrm_pkg::SLOT_W-1:0] dst_slot;
    scrm_pkg::t_row sh_up;
    scrm_pkg::t_row sh_dn;
    scrm_pkg::t_row add_row;
    scrm_pkg::t_row rm_row;
    logic [scrm_pkg::NUM_OUT-1:0] ge;
    logic [scrm_pkg::NUM_OUT-1:0] first_ge;
    logic [scrm_pkg::NUM_OUT-1:0] from_ins;
    logic [scrm_pkg::NUM_OUT-1:0] hit;
    logic [scrm_pkg::NUM_OUT-1:0] first_stop;
    logic [scrm_pkg::NUM_OUT-1:0] from_rm;
    logic dup;
    logic found;

    assign dst_slot = {1'b0, i_dst};
    assign sh_up = {i_row[scrm_pkg::NUM_OUT-2:0], scrm_pkg::EMPTY_SLOT};
    assign sh_dn = {scrm_pkg::EMPTY_SLOT, i_row[scrm_pkg::NUM_OUT-1:1]};

    always_comb begin
        logic acc_ge;
        logic acc_stop;
        logic acc_rm;
        acc_ge   = 1'b0;
        acc_stop = 1'b0;
        acc_rm   = 1'b0;
        for (int j = 0; j < scrm_pkg::NUM_OUT; j++) begin
            ge[j]         = i_row[j] >= dst_slot;
            first_ge[j]   = ge[j] & ~acc_ge;
            acc_ge        = acc_ge | ge[j];
            from_ins[j]   = acc_ge;
            hit[j]        = i_row[j] == dst_slot;
            first_stop[j] = (hit[j] | (i_row[j] == scrm_pkg::EMPTY_SLOT)) & ~acc_stop;
            acc_stop      = acc_stop | hit[j] | (i_row[j] == scrm_pkg::EMPTY_SLOT);
            acc_rm        = acc_rm | (first_stop[j] & hit[j]);
            from_rm[j]    = acc_rm;
        end
    end

    assign dup   = |(first_ge & hit);
    assign found = |(first_stop & hit);

    always_comb begin
        for (int j = 0; j < scrm_pkg::NUM_OUT; j++) begin
            if (!from_ins[j]) begin
                add_row[j] = i_row[j];
            end else if (first_ge[j]) begin
                add_row[j] = dst_slot;
            end else begin
                add_row[j] = sh_up[j];
            end
            rm_row[j] = from_rm[j] ? sh_dn[j] : i_row[j];
        end
    end

    always_comb begin
        case (i_op)
            scrm_pkg::OP_ADD: begin
                o_edit.status = dup ? scrm_pkg::ST_DUP : scrm_pkg::ST_OK;
                o_edit.row    = add_row;
            end
            scrm_pkg::OP_REMOVE: begin
                o_edit.status = found ? scrm_pkg::ST_OK : scrm_pkg::ST_MISSING;
                o_edit.row    = rm_row;
            end
            default: begin
                o_edit.status = scrm_pkg::ST_OK;
                o_edit.row    = i_row;
            end
        endcase
    end

endmodule
`default_nettype wire
